// ----- rtl/lsf_pkg.sv -----
// Shared types, constants and helper functions for the lane segment line fit.
package lsf_pkg;

    // Coordinate and register widths fixed by the stream format.
    localparam int COORD_W = 12;
    localparam int REG_W   = 12;

    // Configuration register indexes.
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Fit sequencer steps, one arithmetic operation each.
    localparam logic [3:0] STEP_N_SRR   = 4'd0;
    localparam logic [3:0] STEP_SR_SR   = 4'd1;
    localparam logic [3:0] STEP_SRR_SC  = 4'd2;
    localparam logic [3:0] STEP_SR_SRC  = 4'd3;
    localparam logic [3:0] STEP_N_SRC   = 4'd4;
    localparam logic [3:0] STEP_SR_SC   = 4'd5;
    localparam logic [3:0] STEP_H_SLOPE = 4'd6;
    localparam logic [3:0] STEP_DIV_BOT = 4'd7;
    localparam logic [3:0] STEP_T_SLOPE = 4'd8;
    localparam logic [3:0] STEP_DIV_TOP = 4'd9;
    localparam logic [3:0] STEP_DIV_OFF = 4'd10;

    // Segment class decided by the front end.
    typedef enum logic [1:0] {
        CLS_DROP,
        CLS_LEFT,
        CLS_RIGHT
    } t_cls;

    // Operation of the shared arithmetic unit.
    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    // Back end sequencer state.
    typedef enum logic [1:0] {
        ST_ACC,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    // One queue entry between front and back.
    typedef struct packed {
        t_cls                cls;
        logic                last;
        logic                ovf;
        logic [COORD_W-1:0]  col_a;
        logic [COORD_W-1:0]  row_a;
        logic [COORD_W-1:0]  col_b;
        logic [COORD_W-1:0]  row_b;
    } t_qent;

    // Command to the arithmetic unit.
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_ctl;

    // Saturate a 64-bit signed value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Clamp a 64-bit signed value to plus or minus two to the fortieth.
    function automatic logic signed [63:0] clamp40(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > (64'sd1 <<< 40)) begin
            r = 64'sd1 <<< 40;
        end else if (v < -(64'sd1 <<< 40)) begin
            r = -(64'sd1 <<< 40);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- rtl/lsf_front.sv -----
// Front end: accepts segment beats, classifies by slope and tracks capacity.
module lsf_front #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int COORD_BITS   = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lsf_pkg::COORD_W-1:0]    i_col_a,
    input  logic [lsf_pkg::COORD_W-1:0]    i_row_a,
    input  logic [lsf_pkg::COORD_W-1:0]    i_col_b,
    input  logic [lsf_pkg::COORD_W-1:0]    i_row_b,
    input  logic                           i_present,
    input  logic                           i_last,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lsf_pkg::t_qent                 o_entry
);

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CW    = lsf_pkg::COORD_W;
    localparam logic [CW-1:0] CMASK =
        (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << COORD_BITS) - 64'd1);

    logic [CNT_W-1:0] r_seen, n_seen;
    logic             r_ovf, n_ovf;
    logic             accept, full_now, ovf_now;
    logic [CW-1:0]    ca, ra, cb, rb;
    logic signed [CW:0]   dx, dy, adx, ady;
    logic signed [CW+4:0] dy5;
    lsf_pkg::t_cls    cls;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // Keep only the coordinate bits in use.
    assign ca = i_col_a & CMASK;
    assign ra = i_row_a & CMASK;
    assign cb = i_col_b & CMASK;
    assign rb = i_row_b & CMASK;

    // Exact slope test with the column change made positive.
    always_comb begin
        dx  = $signed({1'b0, cb}) - $signed({1'b0, ca});
        dy  = $signed({1'b0, rb}) - $signed({1'b0, ra});
        adx = dx[CW] ? -dx : dx;
        ady = dx[CW] ? -dy : dy;
        dy5 = (CW+5)'(ady) * (CW+5)'(5);
        if (!i_present || full_now || dx == '0) begin
            cls = lsf_pkg::CLS_DROP;
        end else if (dy5 < -(CW+5)'(adx)) begin
            cls = lsf_pkg::CLS_LEFT;
        end else if (dy5 > (CW+5)'(adx)) begin
            cls = lsf_pkg::CLS_RIGHT;
        end else begin
            cls = lsf_pkg::CLS_DROP;
        end
    end

    // Capacity count and overflow flag for the current frame.
    always_comb begin
        full_now = (r_seen >= CNT_W'(MAX_SEGMENTS));
        ovf_now  = r_ovf || (i_present && full_now);
        n_seen   = r_seen;
        n_ovf    = r_ovf;
        if (accept) begin
            if (i_last) begin
                n_seen = '0;
                n_ovf  = 1'b0;
            end else begin
                n_ovf = ovf_now;
                if (i_present && !full_now) begin
                    n_seen = r_seen + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_ovf  <= n_ovf;
        end
    end

    // Only kept segments and frame ends go to the queue.
    assign o_push        = accept && (cls != lsf_pkg::CLS_DROP || i_last);
    assign o_entry.cls   = cls;
    assign o_entry.last  = i_last;
    assign o_entry.ovf   = ovf_now;
    assign o_entry.col_a = ca;
    assign o_entry.row_a = ra;
    assign o_entry.col_b = cb;
    assign o_entry.row_b = rb;

endmodule

// ----- rtl/lsf_queue.sv -----
// Short queue that decouples the front end from the back end.
module lsf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lsf_pkg::t_qent  i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output lsf_pkg::t_qent  o_entry
);

    lsf_pkg::t_qent r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

// ----- rtl/lsf_alu.sv -----
// Shared bit-serial signed multiplier and divider, one bit per cycle.
module lsf_alu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lsf_pkg::t_alu_ctl   i_ctl,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic                o_done,
    output logic signed [63:0]  o_res
);

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    lsf_pkg::t_op r_op;
    logic        r_neg;
    logic [63:0] r_a, r_b, r_acc;
    logic signed [63:0] r_res;
    logic [63:0] rem_sh, a_sh, mag_a, mag_b;
    logic        ge;

    assign mag_a = i_a[63] ? 64'(-i_a) : 64'(i_a);
    assign mag_b = i_b[63] ? 64'(-i_b) : 64'(i_b);

    // One restoring division step.
    assign rem_sh = {r_acc[62:0], r_a[63]};
    assign ge     = (rem_sh >= r_b);
    assign a_sh   = {r_a[62:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift-add multiply or shift-subtract divide on magnitudes.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_neg <= i_a[63] ^ i_b[63];
            r_a   <= mag_a;
            r_b   <= mag_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_op == lsf_pkg::OP_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[62:0], 1'b0};
                r_b <= {1'b0, r_b[63:1]};
            end else begin
                r_acc <= ge ? (rem_sh - r_b) : rem_sh;
                r_a   <= a_sh;
            end
        end
        if (r_busy && r_cnt == 6'd63) begin
            if (r_op == lsf_pkg::OP_MUL) begin
                r_res <= r_neg ? -$signed(r_acc + (r_b[0] ? r_a : 64'd0))
                               :  $signed(r_acc + (r_b[0] ? r_a : 64'd0));
            end else begin
                r_res <= r_neg ? -$signed(a_sh) : $signed(a_sh);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/lsf_back.sv -----
// Back end: accumulates least-squares sums and runs the per-frame fit.
module lsf_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  lsf_pkg::t_qent                i_q_entry,
    output logic                          o_q_pop,
    input  logic [lsf_pkg::REG_W-1:0]     i_width,
    input  logic [lsf_pkg::REG_W-1:0]     i_height,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [111:0]                  o_data
);

    lsf_pkg::t_state r_state, n_state;
    logic [3:0]  r_step, n_step;
    logic        r_side, n_side;
    logic        r_ovf, n_ovf;

    // Per-side running sums.
    logic [11:0] r_n   [2];
    logic [23:0] r_sr  [2];
    logic [23:0] r_sc  [2];
    logic [35:0] r_srr [2];
    logic [35:0] r_src [2];

    logic signed [63:0] r_t, n_t, r_det, n_det, r_base, n_base;
    logic signed [63:0] r_slope, n_slope, r_bot, n_bot;
    logic        r_odet [2];
    logic signed [15:0] r_obot [2];
    logic signed [15:0] r_otop [2];
    logic signed [15:0] r_ooff [2];
    logic        wr_res, wr_det;
    logic signed [15:0] wr_bot, wr_top, wr_off;

    lsf_pkg::t_alu_ctl alu_ctl;
    logic signed [63:0] alu_a, alu_b, alu_res;
    logic        alu_done;

    logic [23:0] p_aa, p_ac, p_bb, p_bc;
    logic [14:0] h7;
    logic [30:0] h7_scaled;
    logic [11:0] top_row;
    logic signed [63:0] s_n, s_sr, s_sc, s_srr, s_src, w64, u, num, det_now;
    logic        add_left, add_right, clear_sums;

    // Upper row is floor(7*H/10) through a reciprocal multiply.
    assign h7        = 15'(i_height) * 15'd7;
    assign h7_scaled = 31'(h7) * 31'd52429;
    assign top_row   = 12'(h7_scaled >> 19);

    // Point products for the two endpoints.
    assign p_aa = i_q_entry.row_a * i_q_entry.row_a;
    assign p_ac = i_q_entry.row_a * i_q_entry.col_a;
    assign p_bb = i_q_entry.row_b * i_q_entry.row_b;
    assign p_bc = i_q_entry.row_b * i_q_entry.col_b;

    // Sums of the side under fit, as signed operands.
    assign s_n   = $signed(64'(r_n[r_side]));
    assign s_sr  = $signed(64'(r_sr[r_side]));
    assign s_sc  = $signed(64'(r_sc[r_side]));
    assign s_srr = $signed(64'(r_srr[r_side]));
    assign s_src = $signed(64'(r_src[r_side]));
    assign w64   = $signed(64'(i_width));
    assign u     = lsf_pkg::clamp40(r_bot);
    assign num   = r_side ? ((u <<< 12) - (w64 <<< 11)) : ((w64 <<< 11) - (u <<< 12));
    assign det_now = r_t - alu_res;

    // Operand selection for each fit step.
    always_comb begin
        alu_a = s_n;
        alu_b = s_srr;
        case (r_step)
            lsf_pkg::STEP_N_SRR:   begin alu_a = s_n;   alu_b = s_srr;   end
            lsf_pkg::STEP_SR_SR:   begin alu_a = s_sr;  alu_b = s_sr;    end
            lsf_pkg::STEP_SRR_SC:  begin alu_a = s_srr; alu_b = s_sc;    end
            lsf_pkg::STEP_SR_SRC:  begin alu_a = s_sr;  alu_b = s_src;   end
            lsf_pkg::STEP_N_SRC:   begin alu_a = s_n;   alu_b = s_src;   end
            lsf_pkg::STEP_SR_SC:   begin alu_a = s_sr;  alu_b = s_sc;    end
            lsf_pkg::STEP_H_SLOPE: begin alu_a = $signed(64'(i_height)); alu_b = r_slope; end
            lsf_pkg::STEP_DIV_BOT: begin alu_a = r_t;   alu_b = r_det;   end
            lsf_pkg::STEP_T_SLOPE: begin alu_a = $signed(64'(top_row)); alu_b = r_slope; end
            lsf_pkg::STEP_DIV_TOP: begin alu_a = r_t;   alu_b = r_det;   end
            lsf_pkg::STEP_DIV_OFF: begin alu_a = num;   alu_b = w64;     end
            default:               begin alu_a = s_n;   alu_b = s_srr;   end
        endcase
    end

    // Sequencer: accumulate, then two passes of the fit, then the result beat.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_side  = r_side;
        n_ovf   = r_ovf;
        n_t     = r_t;
        n_det   = r_det;
        n_base  = r_base;
        n_slope = r_slope;
        n_bot   = r_bot;
        o_q_pop = 1'b0;
        add_left  = 1'b0;
        add_right = 1'b0;
        clear_sums = 1'b0;
        alu_ctl.start = 1'b0;
        alu_ctl.op = (r_step == lsf_pkg::STEP_DIV_BOT || r_step == lsf_pkg::STEP_DIV_TOP
                      || r_step == lsf_pkg::STEP_DIV_OFF) ? lsf_pkg::OP_DIV : lsf_pkg::OP_MUL;
        wr_res = 1'b0;
        wr_det = 1'b0;
        wr_bot = '0;
        wr_top = '0;
        wr_off = '0;
        case (r_state)
            lsf_pkg::ST_ACC: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    add_left  = (i_q_entry.cls == lsf_pkg::CLS_LEFT);
                    add_right = (i_q_entry.cls == lsf_pkg::CLS_RIGHT);
                    if (i_q_entry.last) begin
                        n_ovf   = i_q_entry.ovf;
                        n_side  = 1'b0;
                        n_step  = lsf_pkg::STEP_N_SRR;
                        n_state = lsf_pkg::ST_ISSUE;
                    end
                end
            end
            lsf_pkg::ST_ISSUE: begin
                alu_ctl.start = 1'b1;
                n_state = lsf_pkg::ST_WAIT;
            end
            lsf_pkg::ST_WAIT: begin
                if (alu_done) begin
                    n_step  = r_step + 4'd1;
                    n_state = lsf_pkg::ST_ISSUE;
                    case (r_step)
                        lsf_pkg::STEP_N_SRR:   n_t = alu_res;
                        lsf_pkg::STEP_SR_SR: begin
                            n_det = det_now;
                            if (r_n[r_side] < 12'd2 || det_now[63] || det_now == '0) begin
                                wr_res = 1'b1;
                            end
                        end
                        lsf_pkg::STEP_SRR_SC:  n_t = alu_res;
                        lsf_pkg::STEP_SR_SRC:  n_base = r_t - alu_res;
                        lsf_pkg::STEP_N_SRC:   n_t = alu_res;
                        lsf_pkg::STEP_SR_SC:   n_slope = r_t - alu_res;
                        lsf_pkg::STEP_H_SLOPE: n_t = r_base + alu_res;
                        lsf_pkg::STEP_DIV_BOT: n_bot = alu_res;
                        lsf_pkg::STEP_T_SLOPE: n_t = r_base + alu_res;
                        lsf_pkg::STEP_DIV_TOP: begin
                            wr_det = 1'b1;
                            wr_bot = lsf_pkg::sat16(r_bot);
                            wr_top = lsf_pkg::sat16(alu_res);
                            if (i_width == '0) begin
                                wr_res = 1'b1;
                            end
                        end
                        lsf_pkg::STEP_DIV_OFF: begin
                            wr_res = 1'b1;
                            wr_det = 1'b1;
                            wr_bot = r_otop[r_side] == r_otop[r_side] ? r_obot[r_side] : '0;
                            wr_top = r_otop[r_side];
                            wr_off = lsf_pkg::sat16(alu_res);
                        end
                        default: n_t = r_t;
                    endcase
                    // A finished side moves on to the next side or the result.
                    if (wr_res) begin
                        n_step = lsf_pkg::STEP_N_SRR;
                        if (!r_side) begin
                            n_side = 1'b1;
                        end else begin
                            clear_sums = 1'b1;
                            n_state = lsf_pkg::ST_OUT;
                        end
                    end
                end
            end
            lsf_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = lsf_pkg::ST_ACC;
                end
            end
            default: n_state = lsf_pkg::ST_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsf_pkg::ST_ACC;
            r_step  <= '0;
            r_side  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_side  <= n_side;
            r_ovf   <= n_ovf;
        end
    end

    // Fit working registers.
    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_det   <= n_det;
        r_base  <= n_base;
        r_slope <= n_slope;
        r_bot   <= n_bot;
    end

    // Result fields of each side; the top column is written before the offset.
    always_ff @(posedge i_clk) begin
        if (r_state == lsf_pkg::ST_WAIT && alu_done
            && (wr_res || r_step == lsf_pkg::STEP_DIV_TOP)) begin
            r_odet[r_side] <= wr_det;
            r_obot[r_side] <= wr_bot;
            r_otop[r_side] <= wr_top;
            r_ooff[r_side] <= wr_off;
        end
    end

    // Running sums, cleared by reset and after each fit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_sums) begin
            for (int s = 0; s < 2; s++) begin
                r_n[s]   <= '0;
                r_sr[s]  <= '0;
                r_sc[s]  <= '0;
                r_srr[s] <= '0;
                r_src[s] <= '0;
            end
        end else if (add_left || add_right) begin
            r_n[add_right]   <= r_n[add_right] + 12'd2;
            r_sr[add_right]  <= r_sr[add_right] + 24'(i_q_entry.row_a) + 24'(i_q_entry.row_b);
            r_sc[add_right]  <= r_sc[add_right] + 24'(i_q_entry.col_a) + 24'(i_q_entry.col_b);
            r_srr[add_right] <= r_srr[add_right] + 36'(p_aa) + 36'(p_bb);
            r_src[add_right] <= r_src[add_right] + 36'(p_ac) + 36'(p_bc);
        end
    end

    lsf_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (alu_ctl),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // Result beat.
    assign o_valid = (r_state == lsf_pkg::ST_OUT);
    assign o_data  = {1'b0, r_ovf, top_row,
                      r_ooff[1], r_otop[1], r_obot[1], r_odet[1],
                      r_ooff[0], r_otop[0], r_obot[0], r_odet[0]};

endmodule

// ----- rtl/lane_segment_line_fit.sv -----
// Lane segment line fit: top level with configuration registers.
// A frame's result beat follows the fit that starts once its last beat, and any beats still queued
// ahead of it, have been popped; a side that is not detected ends its pass of the fit early.
// The fit runs up to 22 shared multiply or divide operations, each as issue, 64 serial steps, done.
// Throughput: one segment beat per cycle; during a fit the back end stops popping, so input
// stalls once the four-entry queue is full, until the result beat is taken.
// Synchronous active-low reset clears sums and counters; width 640, height 480.
module lane_segment_line_fit #(
    parameter int MAX_SEGMENTS = 1024,
    parameter int COORD_BITS   = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // col_a[11:0], row_a[23:12], col_b[35:24], row_b[47:36]
    input  logic [47:0]  i_s_tdata,
    // segment_present[0]
    input  logic         i_s_tuser,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // left_detected[0], left_bottom_col[16:1], left_top_col[32:17],
    // left_offset[48:33], right_detected[49], right_bottom_col[65:50],
    // right_top_col[81:66], right_offset[97:82], upper_row[109:98],
    // segment_overflow[110], zero pad[111]
    output logic [111:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [11:0]  i_cfg_wdata
);

    logic [lsf_pkg::REG_W-1:0] r_width, r_height;
    logic           q_full, q_push, q_pop, q_valid;
    lsf_pkg::t_qent q_in, q_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 12'd640;
            r_height <= 12'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lsf_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata;
                lsf_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default:                   r_width  <= r_width;
            endcase
        end
    end

    lsf_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_col_a   (i_s_tdata[11:0]),
        .i_row_a   (i_s_tdata[23:12]),
        .i_col_b   (i_s_tdata[35:24]),
        .i_row_b   (i_s_tdata[47:36]),
        .i_present (i_s_tuser),
        .i_last    (i_s_tlast),
        .i_q_full  (q_full),
        .o_push    (q_push),
        .o_entry   (q_in)
    );

    lsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_out)
    );

    lsf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_out),
        .o_q_pop   (q_pop),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata)
    );

endmodule
